FILE: sv/bdpe_pkg.sv
// ----------------------------------------------------------------------------
// bdpe_pkg
// Shared types and constants of the binary delta patch encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpe_pkg;

    localparam int CLOSE_GAP_DEF = 12;
    localparam int POS_W_DEF     = 32;

    localparam int LEN_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int GAP_W   = 7;
    localparam int MAX_REC = 3;
    localparam int CNT_W   = 2;

    localparam logic [GAP_W-1:0] GAP_MAX = '1;

    localparam logic FUNC_COMPARE = 1'b0;
    localparam logic FUNC_CLOSE   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // Queue between the classifier and the record serializer
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  offset;
        logic [LEN_W-1:0]  replaced;
        logic [BYTE_W-1:0] data;
    } t_rec;

    // All records caused by one input item
    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        t_rec [MAX_REC-1:0]     rec;
    } t_bundle;

endpackage

`default_nettype wire

FILE: sv/bdpe_front.sv
// ----------------------------------------------------------------------------
// bdpe_front
// Accepts byte pairs and close commands, tracks the patch state and builds
// the group of patch records that each item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpe_front #(
    parameter int CLOSE_GAP      = bdpe_pkg::CLOSE_GAP_DEF,
    parameter int POSITION_WIDTH = bdpe_pkg::POS_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [bdpe_pkg::LEN_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_func,
    input  wire logic [bdpe_pkg::BYTE_W-1:0]   i_new_byte,
    input  wire logic [bdpe_pkg::BYTE_W-1:0]   i_old_byte,
    input  wire logic                          i_q_ready,
    output logic                               o_push,
    output bdpe_pkg::t_bundle                  o_bundle
);

    localparam int CMP_W = (POSITION_WIDTH > bdpe_pkg::LEN_W) ?
                           POSITION_WIDTH : bdpe_pkg::LEN_W;
    localparam logic [bdpe_pkg::GAP_W-1:0] GAP_LIMIT = bdpe_pkg::GAP_W'(CLOSE_GAP);
    localparam logic [bdpe_pkg::GAP_W-1:0] GAP_ONE   = bdpe_pkg::GAP_W'(1);
    localparam logic [bdpe_pkg::LEN_W-1:0] REP_ONE   = bdpe_pkg::LEN_W'(1);

    logic [bdpe_pkg::LEN_W-1:0]   r_old_length;
    logic [POSITION_WIDTH-1:0]    r_position,  n_position;
    logic                         r_open,      n_open;
    logic                         r_pending,   n_pending;
    logic [bdpe_pkg::GAP_W-1:0]   r_gap,       n_gap;
    logic [bdpe_pkg::LEN_W-1:0]   r_rep,       n_rep;

    logic                         accept;
    logic [CMP_W-1:0]             pos_ext;
    logic [CMP_W-1:0]             old_ext;
    logic                         past_end;
    logic                         same;
    logic                         advance_gap;
    logic [bdpe_pkg::LEN_W-1:0]   pos_lo;
    bdpe_pkg::t_rec               rec_begin;
    bdpe_pkg::t_rec               rec_data;
    bdpe_pkg::t_rec               rec_end;
    bdpe_pkg::t_rec               rec_trunc;
    bdpe_pkg::t_bundle            bundle;

    assign accept   = i_in_valid & i_q_ready;
    assign pos_ext  = CMP_W'(r_position);
    assign old_ext  = CMP_W'(r_old_length);
    assign pos_lo   = pos_ext[bdpe_pkg::LEN_W-1:0];
    assign past_end = (pos_ext >= old_ext);
    assign same     = (i_new_byte == i_old_byte);

    always_comb begin
        rec_begin          = '0;
        rec_begin.kind     = bdpe_pkg::KIND_BEGIN;
        rec_begin.offset   = pos_lo;
        rec_data           = '0;
        rec_data.kind      = bdpe_pkg::KIND_DATA;
        rec_data.data      = i_new_byte;
        rec_end            = '0;
        rec_end.kind       = bdpe_pkg::KIND_END;
        rec_end.replaced   = r_rep;
        rec_trunc          = '0;
        rec_trunc.kind     = bdpe_pkg::KIND_END;
        rec_trunc.replaced = r_old_length - pos_lo;
    end

    always_comb begin
        n_position  = r_position;
        n_open      = r_open;
        n_pending   = r_pending;
        n_gap       = r_gap;
        n_rep       = r_rep;
        advance_gap = 1'b1;
        bundle      = '0;

        if (i_func == bdpe_pkg::FUNC_CLOSE) begin
            if (r_open) begin
                bundle.rec[bundle.cnt] = rec_end;
                bundle.cnt             = bundle.cnt + 1'b1;
            end
            if (!past_end) begin
                bundle.rec[bundle.cnt] = rec_begin;
                bundle.cnt             = bundle.cnt + 1'b1;
                bundle.rec[bundle.cnt] = rec_trunc;
                bundle.cnt             = bundle.cnt + 1'b1;
            end
            n_position = '0;
            n_open     = 1'b0;
            n_pending  = 1'b0;
            n_gap      = '0;
            n_rep      = '0;
        end else begin
            if (past_end) begin
                // append past the old end: no old bytes replaced
                if (!r_open) begin
                    bundle.rec[bundle.cnt] = rec_begin;
                    bundle.cnt             = bundle.cnt + 1'b1;
                    n_open                 = 1'b1;
                    n_rep                  = '0;
                end
                bundle.rec[bundle.cnt] = rec_data;
                bundle.cnt             = bundle.cnt + 1'b1;
            end else if (same && r_pending && (r_gap > GAP_LIMIT)) begin
                // gap long enough: end the patch, drop this matching byte
                if (r_open) begin
                    bundle.rec[bundle.cnt] = rec_end;
                    bundle.cnt             = bundle.cnt + 1'b1;
                end
                n_open      = 1'b0;
                n_rep       = '0;
                n_pending   = 1'b0;
                n_gap       = '0;
                advance_gap = 1'b0;
            end else if (!same || r_pending) begin
                if (!same) begin
                    n_pending   = 1'b1;
                    n_gap       = GAP_ONE;
                    advance_gap = 1'b0;
                end
                if (!r_open) begin
                    bundle.rec[bundle.cnt] = rec_begin;
                    bundle.cnt             = bundle.cnt + 1'b1;
                    n_open                 = 1'b1;
                    n_rep                  = REP_ONE;
                end else if (r_rep != '1) begin
                    n_rep = r_rep + 1'b1;
                end
                bundle.rec[bundle.cnt] = rec_data;
                bundle.cnt             = bundle.cnt + 1'b1;
            end
            if (advance_gap && n_pending && (n_gap != bdpe_pkg::GAP_MAX)) begin
                n_gap = n_gap + 1'b1;
            end
            n_position = r_position + 1'b1;
        end
    end

    assign o_push   = accept & (bundle.cnt != '0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_length <= '0;
            r_position   <= '0;
            r_open       <= 1'b0;
            r_pending    <= 1'b0;
            r_gap        <= '0;
            r_rep        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_old_length <= i_cfg_data;
            end
            if (accept) begin
                r_position <= n_position;
                r_open     <= n_open;
                r_pending  <= n_pending;
                r_gap      <= n_gap;
                r_rep      <= n_rep;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/bdpe_queue.sv
// ----------------------------------------------------------------------------
// bdpe_queue
// Short first-in first-out queue of record groups between the classifier
// and the record serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpe_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire bdpe_pkg::t_bundle  i_bundle,
    output logic                    o_ready,
    input  wire logic               i_pop,
    output logic                    o_valid,
    output bdpe_pkg::t_bundle       o_bundle
);

    localparam logic [bdpe_pkg::QAW:0] FULL_CNT = (bdpe_pkg::QAW+1)'(bdpe_pkg::QDEPTH);
    localparam logic [bdpe_pkg::QAW-1:0] LAST_PTR =
        bdpe_pkg::QAW'(bdpe_pkg::QDEPTH - 1);

    bdpe_pkg::t_bundle            r_mem [bdpe_pkg::QDEPTH];
    logic [bdpe_pkg::QAW-1:0]     r_wptr;
    logic [bdpe_pkg::QAW-1:0]     r_rptr;
    logic [bdpe_pkg::QAW:0]       r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_ready  = (r_count != FULL_CNT);
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rptr];
    assign do_push  = i_push & o_ready;
    assign do_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/bdpe_back.sv
// ----------------------------------------------------------------------------
// bdpe_back
// Serializes each record group into single records on a registered output
// stage, marking the final record of the group.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpe_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire bdpe_pkg::t_bundle             i_bundle,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bdpe_pkg::KIND_W-1:0]        o_kind,
    output logic [bdpe_pkg::LEN_W-1:0]         o_offset,
    output logic [bdpe_pkg::LEN_W-1:0]         o_replaced,
    output logic [bdpe_pkg::BYTE_W-1:0]        o_data,
    output logic                               o_last
);

    logic                          r_valid;
    logic [bdpe_pkg::CNT_W-1:0]    r_idx;
    bdpe_pkg::t_rec                r_rec;
    logic                          r_last;
    logic                          load;
    logic                          is_last;

    assign load    = i_q_valid & (~r_valid | i_out_ready);
    assign is_last = (r_idx == (i_bundle.cnt - 1'b1));
    assign o_pop   = load & is_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec  <= i_bundle.rec[r_idx];
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                // advance within the group, wrap when it is drained
                r_idx   <= is_last ? '0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_rec.kind;
    assign o_offset    = r_rec.offset;
    assign o_replaced  = r_rec.replaced;
    assign o_data      = r_rec.data;
    assign o_last      = r_last;

endmodule

`default_nettype wire

FILE: sv/binary_delta_patch_encoder_core.sv
// Records of each accepted item pass through the queue, then the output register.
// Throughput: one item per cycle while the output is ready and each item causes at
// most one record; records leave one per cycle, so a k-record item holds the output.
// The two-entry queue between classifier and serializer decouples the two sides.
// Reset (synchronous, active low) clears position, patch state, queue and
// output, and sets old_length to zero.
// ----------------------------------------------------------------------------
// binary_delta_patch_encoder_core
// Compares a new byte stream with an old buffer and emits patch records.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_delta_patch_encoder_core #(
    parameter int CLOSE_GAP      = bdpe_pkg::CLOSE_GAP_DEF,
    parameter int POSITION_WIDTH = bdpe_pkg::POS_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bdpe_pkg::LEN_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_func,
    input  wire logic [bdpe_pkg::BYTE_W-1:0]   i_new_byte,
    input  wire logic [bdpe_pkg::BYTE_W-1:0]   i_old_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bdpe_pkg::KIND_W-1:0]        o_kind,
    output logic [bdpe_pkg::LEN_W-1:0]         o_offset,
    output logic [bdpe_pkg::LEN_W-1:0]         o_replaced,
    output logic [bdpe_pkg::BYTE_W-1:0]        o_data,
    output logic                               o_last
);

    logic                 q_ready;
    logic                 push;
    bdpe_pkg::t_bundle    push_bundle;
    logic                 q_valid;
    bdpe_pkg::t_bundle    head_bundle;
    logic                 pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = q_ready;

    bdpe_front #(
        .CLOSE_GAP      (CLOSE_GAP),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_new_byte  (i_new_byte),
        .i_old_byte  (i_old_byte),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_bundle    (push_bundle)
    );

    bdpe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_ready  (q_ready),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_bundle (head_bundle)
    );

    bdpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_bundle    (head_bundle),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_offset    (o_offset),
        .o_replaced  (o_replaced),
        .o_data      (o_data),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: binary delta patch encoder core
// Streams byte pairs and closes through the core under random idling on
// both sides, predicts the patch records of every accepted item, and
// compares each record leaving the core field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdpe_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 470;
    localparam int unsigned MAX_IDLE     = 18;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned STALL_LIMIT  = 4000;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  offset;
        logic [LEN_W-1:0]  replaced;
        logic [BYTE_W-1:0] data;
        logic              last;
    } patch_rec_t;

    // Tracks the diff state of the core and the records it still owes.
    class patch_stream_model;
        logic [LEN_W-1:0]     old_len;
        logic [POS_W_DEF-1:0] pos;
        logic                 patch_open;
        logic                 diff_pending;
        logic [GAP_W-1:0]     gap;
        logic [LEN_W-1:0]     repl;
        patch_rec_t           owed_records[$];
        int unsigned          n_errors;
        int unsigned          n_checked;

        function new();
            old_len = '0;
            n_errors = 0;
            n_checked = 0;
            clear_diff();
        endfunction

        function void clear_diff();
            pos = '0;
            patch_open = 1'b0;
            diff_pending = 1'b0;
            gap = '0;
            repl = '0;
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            old_len = len;
        endfunction

        function void owe(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] offset,
                          logic [LEN_W-1:0] replaced, logic [BYTE_W-1:0] data);
            patch_rec_t r;
            r.kind = kind;
            r.offset = offset;
            r.replaced = replaced;
            r.data = data;
            r.last = 1'b0;
            owed_records.insert(owed_records.size(), r);
        endfunction

        function void note_item(logic f, logic [BYTE_W-1:0] nb, logic [BYTE_W-1:0] ob);
            int unsigned first;
            bit          step_gap;
            first = owed_records.size();
            step_gap = 1'b1;
            if (f == FUNC_CLOSE) begin
                if (patch_open)
                    owe(KIND_END, '0, repl, '0);
                if (pos < old_len) begin
                    owe(KIND_BEGIN, LEN_W'(pos), '0, '0);
                    owe(KIND_END, '0, LEN_W'(old_len - pos), '0);
                end
                clear_diff();
            end else begin
                if (pos >= old_len) begin
                    // append past the old end: no old bytes replaced
                    if (!patch_open) begin
                        owe(KIND_BEGIN, LEN_W'(pos), '0, '0);
                        patch_open = 1'b1;
                        repl = '0;
                    end
                    owe(KIND_DATA, '0, '0, nb);
                end else if (nb == ob && diff_pending && int'(gap) > CLOSE_GAP_DEF) begin
                    if (patch_open)
                        owe(KIND_END, '0, repl, '0);
                    patch_open = 1'b0;
                    repl = '0;
                    diff_pending = 1'b0;
                    gap = '0;
                    step_gap = 1'b0;
                end else if (nb != ob || diff_pending) begin
                    if (nb != ob) begin
                        diff_pending = 1'b1;
                        gap = GAP_W'(1);
                        step_gap = 1'b0;
                    end
                    if (!patch_open) begin
                        owe(KIND_BEGIN, LEN_W'(pos), '0, '0);
                        patch_open = 1'b1;
                        repl = '0;
                    end
                    if (repl != '1)
                        repl++;
                    owe(KIND_DATA, '0, '0, nb);
                end
                if (step_gap && diff_pending && gap != GAP_MAX)
                    gap++;
                pos = pos + 1'b1;
            end
            if (owed_records.size() > first)
                owed_records[owed_records.size() - 1].last = 1'b1;
        endfunction

        function void cmp_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_record(patch_rec_t got);
            patch_rec_t want;
            n_checked++;
            if (owed_records.size() == 0) begin
                $error("unexpected record: kind %0d offset 0x%0h replaced 0x%0h data 0x%0h",
                       got.kind, got.offset, got.replaced, got.data);
                n_errors++;
                return;
            end
            want = owed_records.pop_front();
            cmp_field("kind", LEN_W'(want.kind), LEN_W'(got.kind));
            cmp_field("offset", want.offset, got.offset);
            cmp_field("replaced", want.replaced, got.replaced);
            cmp_field("data", LEN_W'(want.data), LEN_W'(got.data));
            cmp_field("last", LEN_W'(want.last), LEN_W'(got.last));
        endfunction

        function int unsigned pending();
            return owed_records.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [LEN_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_func;
    logic [BYTE_W-1:0]   i_new_byte;
    logic [BYTE_W-1:0]   i_old_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KIND_W-1:0]   o_kind;
    logic [LEN_W-1:0]    o_offset;
    logic [LEN_W-1:0]    o_replaced;
    logic [BYTE_W-1:0]   o_data;
    logic                o_last;

    patch_stream_model   pred;
    logic [LEN_W-1:0]    cur_len;
    int unsigned         n_items;
    int unsigned         n_lengths;
    bit                  tx_fast;
    bit                  hold_req;

    binary_delta_patch_encoder_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic write_length(input logic [LEN_W-1:0] len);
        i_cfg_valid = 1'b1;
        i_cfg_data = len;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred.set_length(len);
        cur_len = len;
        n_lengths++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_item(input logic f, input logic [BYTE_W-1:0] nb,
                             input logic [BYTE_W-1:0] ob);
        int unsigned idle;
        if ($urandom_range(0, 39) == 0)
            tx_fast = !tx_fast;
        idle = tx_fast ? 0 : $urandom_range(0, MAX_IDLE);
        repeat (idle) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_func = f;
        i_new_byte = nb;
        i_old_byte = ob;
        do @(posedge i_clk); while (!o_in_ready);
        pred.note_item(f, nb, ob);
        n_items++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Hold until every owed record is out, then let in-flight items settle.
    task automatic wait_idle();
        while (pred.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_file(input int unsigned nbytes, input int unsigned pct);
        logic [BYTE_W-1:0] nb;
        logic [BYTE_W-1:0] ob;
        for (int unsigned i = 0; i < nbytes; i++) begin
            ob = 8'($urandom);
            if ($urandom_range(0, 99) < pct)
                nb = ob ^ 8'($urandom_range(1, 255));
            else
                nb = ob;
            if ($urandom_range(0, 49) == 0)
                nb = 8'($urandom);
            // cut the file short now and then
            if ($urandom_range(0, 79) == 0)
                send_item(FUNC_CLOSE, nb, ob);
            else
                send_item(FUNC_COMPARE, nb, ob);
        end
        send_item(FUNC_CLOSE, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 9) == 0)
            send_item(FUNC_CLOSE, 8'($urandom), 8'($urandom));
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] b;
        logic [LEN_W-1:0]  len;
        int unsigned       random_start;
        int unsigned       base;
        int unsigned       new_len;
        int unsigned       pct;
        int unsigned       sel;
        bit                first;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_func = FUNC_COMPARE;
        i_new_byte = '0;
        i_old_byte = '0;
        cur_len = '0;
        n_items = 0;
        n_lengths = 0;
        tx_fast = 1'b0;
        hold_req = 1'b0;
        pred = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty old buffer: idle close, then a patch that only appends
        write_length('0);
        send_item(FUNC_CLOSE, 8'h00, 8'h00);
        send_item(FUNC_COMPARE, 8'hFF, 8'h00);
        send_item(FUNC_COMPARE, 8'h00, 8'hFF);
        send_item(FUNC_CLOSE, 8'hFF, 8'hFF);

        // close with an open patch followed by truncation
        wait_idle();
        write_length(32'd3);
        send_item(FUNC_COMPARE, 8'h00, 8'h00);
        send_item(FUNC_COMPARE, 8'hFF, 8'h00);
        send_item(FUNC_CLOSE, 8'h00, 8'h00);

        // patch running past the old end keeps its replaced count
        wait_idle();
        write_length(32'd2);
        send_item(FUNC_COMPARE, 8'hA5, 8'h5A);
        send_item(FUNC_COMPARE, 8'h5A, 8'h5A);
        send_item(FUNC_COMPARE, 8'h3C, 8'hC3);
        send_item(FUNC_CLOSE, 8'h00, 8'h00);

        // largest old buffer: patch ends on the first match past the gap
        wait_idle();
        write_length('1);
        send_item(FUNC_COMPARE, 8'h01, 8'h02);
        repeat (CLOSE_GAP_DEF + 1) begin
            b = 8'($urandom);
            send_item(FUNC_COMPARE, b, b);
        end
        send_item(FUNC_CLOSE, 8'h00, 8'h00);

        random_start = n_items;
        first = 1'b1;
        hold_req = 1'b1;
        while (n_items - random_start < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: len = '0;
                1: len = '1;
                2: len = $urandom;
                default: len = $urandom_range(1, 48);
            endcase
            wait_idle();
            write_length(len);
            repeat ($urandom_range(1, 3)) begin
                base = (cur_len <= 64) ? int'(cur_len) : $urandom_range(0, 60);
                sel = $urandom_range(0, 15);
                if (sel == 0 && cur_len <= 64)
                    new_len = base + $urandom_range(100, 150);
                else if (sel <= 4)
                    new_len = (base > 0) ? $urandom_range(0, base - 1) : 0;
                else if (sel <= 7)
                    new_len = base + $urandom_range(1, 8);
                else
                    new_len = base;
                case ($urandom_range(0, 3))
                    0: pct = 3;
                    1: pct = 10;
                    2: pct = 30;
                    default: pct = 70;
                endcase
                // dense first file so the held-off output backs up the input
                if (first) begin
                    pct = 70;
                    new_len = new_len + 30;
                    first = 1'b0;
                end
                run_file(new_len, pct);
            end
        end

        wait_idle();
        $display("covered %0d items over %0d old lengths, %0d records checked",
                 n_items, n_lengths, pred.n_checked);
        if (pred.n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : receiver
        int unsigned stall;
        bit          rx_fast;
        bit          held;
        patch_rec_t  got;
        rx_fast = 1'b0;
        held = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_fast = !rx_fast;
            stall = rx_fast ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_req && !held) begin
                held = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.kind = o_kind;
            got.offset = o_offset;
            got.replaced = o_replaced;
            got.data = o_data;
            got.last = o_last;
            pred.check_record(got);
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (i_out_ready && o_out_valid) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
